>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TAHCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tahct: same-cycle check failed");

// Next-cycle implication.
`define TAHCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tahct: next-cycle check failed");

`endif

>>> design/tahct_pkg.sv
// ----------------------------------------------------------------------------
// tahct_pkg
// Types, register codes and servo pulse mapping for the hill-climb tracker.
// ----------------------------------------------------------------------------
package tahct_pkg;

  localparam int unsigned ANGLE_W     = 8;
  localparam int unsigned PULSE_W     = 7;
  localparam int unsigned SAMPLE_IN_W = 16;
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned FLAG_W      = 4;

  // Search phase of one axis
  typedef enum logic [1:0] {
    PH_UP_REF   = 2'd0,
    PH_UP_CLIMB = 2'd1,
    PH_DN_REF   = 2'd2,
    PH_DN_CLIMB = 2'd3
  } phase_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP       = 3'd0,
    CFG_START_Y    = 3'd1,
    CFG_START_X    = 3'd2,
    CFG_FALLBACK_Y = 3'd3,
    CFG_FALLBACK_X = 3'd4
  } cfg_idx_e;

  // Edge flags of the upward climb
  localparam logic [FLAG_W-1:0] FLAG_AT_LIMIT   = 4'b0001;
  localparam logic [FLAG_W-1:0] FLAG_CLAMPED    = 4'b0010;
  localparam logic [FLAG_W-1:0] FLAG_LIMIT_ROSE = 4'b0100;
  localparam logic [FLAG_W-1:0] FLAG_STEPPED    = 4'b1000;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_STEP       = 8'd15;
  localparam logic [CFG_W-1:0] RST_START_Y    = 8'd90;
  localparam logic [CFG_W-1:0] RST_START_X    = 8'd90;
  localparam logic [CFG_W-1:0] RST_FALLBACK_Y = 8'd140;
  localparam logic [CFG_W-1:0] RST_FALLBACK_X = 8'd90;
  localparam logic [ANGLE_W-1:0] RST_ANGLE    = 8'd90;

  // Pulse mapping: floor((k*g - 1) / d) + offset, division by reciprocal.
  // Exact for all 8-bit angles: n*(R*d - 2^17) < 2^17 holds for both axes.
  localparam int unsigned RECIP_SHIFT = 17;
  localparam logic [11:0] PY_RECIP    = 12'd3641;  // ceil(2^17 / 36)
  localparam logic [11:0] PX_RECIP    = 12'd2913;  // ceil(2^17 / 45)
  localparam logic [PULSE_W-1:0] PY_OFFSET = 7'd35;
  localparam logic [PULSE_W-1:0] PX_OFFSET = 7'd30;

  function automatic logic [PULSE_W-1:0] pulse_y_of(input logic [ANGLE_W-1:0] g);
    logic [12:0] n;
    logic [24:0] prod;
    logic [7:0]  q;
    n    = ({5'd0, g} << 4) + {5'd0, g} - 13'd1;
    prod = {12'd0, n} * {13'd0, PY_RECIP};
    q    = 8'(prod >> RECIP_SHIFT);
    if (g == '0) begin
      return PY_OFFSET;
    end
    return PULSE_W'(q + {1'b0, PY_OFFSET});
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_x_of(input logic [ANGLE_W-1:0] g);
    logic [12:0] n;
    logic [24:0] prod;
    logic [7:0]  q;
    n    = ({5'd0, g} << 4) + ({5'd0, g} << 2) + ({5'd0, g} << 1) - 13'd1;
    prod = {12'd0, n} * {13'd0, PX_RECIP};
    q    = 8'(prod >> RECIP_SHIFT);
    if (g == '0) begin
      return PX_OFFSET;
    end
    return PULSE_W'(q + {1'b0, PX_OFFSET});
  endfunction

endpackage

>>> design/two_axis_hill_climb_tracker.sv
// ----------------------------------------------------------------------------
// two_axis_hill_climb_tracker
// Hill-climbing search of a two-axis panel mount, one voltage word per step.
// ----------------------------------------------------------------------------
// Path: an accepted sample word passes the input register, the search update
//   and the pulse mapping register before its result word shows.
// Throughput: one sample word per cycle unless the result side stalls; the
//   search state is updated as a sample moves on to the angle register.
// Reset: asynchronous, active low; clears the pipeline valids, the search
//   state and the configuration registers to their defaults. No clearing pass.
module two_axis_hill_climb_tracker #(
  parameter int unsigned MAX_ANGLE   = 180,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [tahct_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tahct_pkg::CFG_W-1:0]         cfg_data_i,
  // sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tahct_pkg::SAMPLE_IN_W-1:0]   s_axis_tdata,   // [15:0] sample_mv
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] angle_y, [15:8] angle_x, [22:16] pulse_y, [29:23] pulse_x, [31:30] zero
  output logic [tahct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast,   // pass_done
  output logic                                m_axis_tuser    // axis_busy
);
  import tahct_pkg::*;

  localparam logic [ANGLE_W-1:0] MaxA = ANGLE_W'(MAX_ANGLE);
  localparam int unsigned InW = (SAMPLE_BITS < SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] step_q, start_y_q, start_x_q, fb_y_q, fb_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= RST_STEP;
      start_y_q <= RST_START_Y;
      start_x_q <= RST_START_X;
      fb_y_q    <= RST_FALLBACK_Y;
      fb_x_q    <= RST_FALLBACK_X;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STEP:       step_q    <= cfg_data_i;
        CFG_START_Y:    start_y_q <= cfg_data_i;
        CFG_START_X:    start_x_q <= cfg_data_i;
        CFG_FALLBACK_Y: fb_y_q    <= cfg_data_i;
        CFG_FALLBACK_X: fb_x_q    <= cfg_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: stage 1 sample, stage 2 angles, stage 3 result word
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, free3;

  assign free3         = !v3_q || m_axis_tready;
  assign adv2          = v2_q && free3;
  assign adv1          = v1_q && (!v2_q || adv2);
  assign s_axis_tready = !v1_q || adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s_axis_tready) v1_q <= s_axis_tvalid;
      if (!v2_q || adv2) v2_q <= adv1;
      if (free3)         v3_q <= adv2;
    end
  end

  // Stage 1: hold the sample, keeping only the low SAMPLE_BITS bits
  logic [SAMPLE_BITS-1:0] smp_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      smp_q <= SAMPLE_BITS'(s_axis_tdata[InW-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Search state
  // --------------------------------------------------------------------------
  phase_e                 phase_q, phase_d;
  logic                   axis_q, axis_d;       // 0 Y, 1 X
  logic                   started_q, started_d;
  logic [ANGLE_W-1:0]     cur_y_q, cur_y_d, cur_x_q, cur_x_d;
  logic [ANGLE_W-1:0]     origin_q, origin_d;
  logic [ANGLE_W-1:0]     up_q, up_d, dn_q, dn_d;
  logic [SAMPLE_BITS-1:0] ref_q, ref_d, peak_q, peak_d;
  logic [FLAG_W-1:0]      flags_q, flags_d;
  logic                   done_d;

  function automatic logic [ANGLE_W-1:0] lim(input logic [ANGLE_W-1:0] a);
    return (a > MaxA) ? MaxA : a;
  endfunction

  function automatic logic [ANGLE_W-1:0] sub_sat(input logic [ANGLE_W-1:0] a,
                                                 input logic [ANGLE_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_UP_REF;
      axis_q    <= 1'b0;
      started_q <= 1'b0;
      cur_y_q   <= RST_ANGLE;
      cur_x_q   <= RST_ANGLE;
      origin_q  <= '0;
      up_q      <= '0;
      dn_q      <= '0;
      ref_q     <= '0;
      peak_q    <= '0;
      flags_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      axis_q    <= axis_d;
      started_q <= started_d;
      cur_y_q   <= cur_y_d;
      cur_x_q   <= cur_x_d;
      origin_q  <= origin_d;
      up_q      <= up_d;
      dn_q      <= dn_d;
      ref_q     <= ref_d;
      peak_q    <= peak_d;
      flags_q   <= flags_d;
    end
  end

  // Next search state; advances only when the sample moves on to stage 2
  always_comb begin
    logic [ANGLE_W-1:0] cur_axis;
    logic [ANGLE_W-1:0] org;
    logic [ANGLE_W-1:0] new_axis;
    logic [ANGLE_W:0]   sum;
    logic               rose;
    logic               keep;
    logic               pass_end;

    phase_d   = phase_q;
    axis_d    = axis_q;
    started_d = started_q;
    cur_y_d   = cur_y_q;
    cur_x_d   = cur_x_q;
    origin_d  = origin_q;
    up_d      = up_q;
    dn_d      = dn_q;
    ref_d     = ref_q;
    peak_d    = peak_q;
    flags_d   = flags_q;
    done_d    = 1'b0;

    cur_axis  = axis_q ? cur_x_q : cur_y_q;
    org       = '0;
    new_axis  = cur_axis;
    sum       = '0;
    rose      = smp_q > ref_q;
    keep      = 1'b0;
    pass_end  = 1'b0;

    if (adv1) begin
      case (phase_q)
        PH_UP_REF: begin
          // Before the first pass the origin comes from the start register.
          org      = started_q ? cur_axis : lim(axis_q ? start_x_q : start_y_q);
          origin_d = org;
          ref_d    = smp_q;
          if (org < MaxA) begin
            sum = {1'b0, org} + {1'b0, step_q};
            if (sum >= {1'b0, MaxA}) begin
              flags_d = FLAG_CLAMPED;
              up_d    = MaxA;
            end else begin
              flags_d = '0;
              up_d    = sum[ANGLE_W-1:0];
            end
          end else begin
            flags_d = FLAG_AT_LIMIT;
            up_d    = MaxA;
          end
          new_axis = up_d;
          phase_d  = PH_UP_CLIMB;
        end
        PH_UP_CLIMB: begin
          if (rose) begin
            ref_d = smp_q;
            if (up_q >= MaxA) begin
              up_d    = MaxA;
              flags_d = flags_q | FLAG_LIMIT_ROSE;
            end else begin
              flags_d = flags_q | FLAG_STEPPED;
              sum     = {1'b0, up_q} + {1'b0, step_q};
              up_d    = (sum >= {1'b0, MaxA}) ? MaxA : sum[ANGLE_W-1:0];
            end
            new_axis = up_d;
          end else begin
            // Back off one step unless the limit held the climb.
            keep   = |(flags_q & (FLAG_AT_LIMIT | FLAG_LIMIT_ROSE));
            peak_d = ref_q;
            if (!keep) up_d = sub_sat(up_q, step_q);
            new_axis = origin_q;
            phase_d  = PH_DN_REF;
          end
        end
        PH_DN_REF: begin
          ref_d    = smp_q;
          flags_d  = '0;
          dn_d     = sub_sat(origin_q, step_q);
          new_axis = dn_d;
          phase_d  = PH_DN_CLIMB;
        end
        PH_DN_CLIMB: begin
          if (rose) begin
            ref_d    = smp_q;
            dn_d     = sub_sat(dn_q, step_q);
            new_axis = dn_d;
          end else begin
            // Keep the higher peak; the up side wins a tie.
            new_axis = (ref_q > peak_q) ? dn_q : up_q;
            phase_d  = PH_UP_REF;
            if (!axis_q) begin
              axis_d = 1'b1;
            end else begin
              axis_d    = 1'b0;
              started_d = 1'b1;
              done_d    = 1'b1;
              pass_end  = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (axis_q) cur_x_d = new_axis;
      else        cur_y_d = new_axis;

      // End of pass: replace a zero angle by the fallback.
      if (pass_end) begin
        if (cur_x_d == '0) cur_x_d = lim(fb_x_q);
        if (cur_y_d == '0) cur_y_d = lim(fb_y_q);
      end
    end
  end

  // Stage 2: hold the commanded angles and flags of this result
  logic [ANGLE_W-1:0] s2_ang_y_q, s2_ang_x_q;
  logic               s2_busy_q, s2_done_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_ang_y_q <= cur_y_d;
      s2_ang_x_q <= cur_x_d;
      s2_busy_q  <= axis_d;
      s2_done_q  <= done_d;
    end
  end

  // Stage 3: map angles to servo pulses and register the result word
  logic [OUT_TDATA_W-1:0] tdata_q;
  logic                   tlast_q, tuser_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      tdata_q <= {2'b00, pulse_x_of(s2_ang_x_q), pulse_y_of(s2_ang_y_q),
                  s2_ang_x_q, s2_ang_y_q};
      tlast_q <= s2_done_q;
      tuser_q <= s2_busy_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = tlast_q;
  assign m_axis_tuser  = tuser_q;

endmodule

>>> design/tahct_checker.sv
// ----------------------------------------------------------------------------
// tahct_checker
// Port-level checks of the result stream of the hill-climb tracker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tahct_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tahct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                              m_axis_tlast,
  input logic                              m_axis_tuser
);
  import tahct_pkg::*;

  logic                 out_hs;
  logic                 out_stall;
  logic [OUT_TDATA_W+1:0] out_word;
  logic                 last_busy_q;
  logic                 pulses_ok;
  logic [ANGLE_W-1:0]   ang_y, ang_x;
  logic [PULSE_W-1:0]   pls_y, pls_x;

  assign out_hs    = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign ang_y     = m_axis_tdata[7:0];
  assign ang_x     = m_axis_tdata[15:8];
  assign pls_y     = m_axis_tdata[22:16];
  assign pls_x     = m_axis_tdata[29:23];

  // A zero angle maps to the bare pulse offset.
  assign pulses_ok = (ang_y != '0 || pls_y == PY_OFFSET) &&
                     (ang_x != '0 || pls_x == PX_OFFSET);

  // Track the axis flag of the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_busy_q <= 1'b0;
    end else if (out_hs) begin
      last_busy_q <= m_axis_tuser;
    end
  end

  `TAHCT_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))
  `TAHCT_ASSERT_IMP(a_pass_back_to_y, m_axis_tvalid && m_axis_tlast, !m_axis_tuser)
  `TAHCT_ASSERT_IMP(a_pass_after_x, out_hs && m_axis_tlast, last_busy_q)
  `TAHCT_ASSERT_IMP(a_zero_pulse, m_axis_tvalid, pulses_ok)

endmodule

bind two_axis_hill_climb_tracker tahct_checker u_tahct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
